FILE: src/dpms_pkg.sv
// shared constants and types for the degenerate pattern mismatch search
package dpms_pkg;

	localparam int PATTERN_SLOTS     = 16;
	localparam int MAX_PATTERN_LEN   = 32;
	localparam int CODE_BITS         = 4;
	localparam int BASES_PER_WORD    = 16;
	localparam int WORD_BITS         = 64;
	localparam int WORDS_PER_PATTERN = 2;
	localparam int PAT_POS           = WORDS_PER_PATTERN * BASES_PER_WORD;

	typedef logic [WORDS_PER_PATTERN-1:0][WORD_BITS-1:0] pat_words_t;

	typedef struct packed {
		logic [3:0]         pattern_index;
		logic [31:0]        location;
		logic signed [7:0]  mismatch_count;
		logic               last;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic        flush;
		logic [3:0]  index;
		logic [31:0] location;
	} slot_t;

	typedef struct packed {
		logic    valid;
		logic    flush;
		logic    match;
		result_t res;
	} score_t;

endpackage

FILE: src/degenerate_pattern_mismatch_search_unit.sv
// top level of the degenerate pattern mismatch search unit
//
// input channel (in_valid / in_stall): one request per item. action load
// writes one 64-bit word of a pattern into the store, action base pushes one
// genome base into the window, action restart clears window and position.
// loads, restarts, unused actions and bases that do not fill the window end
// when accepted. a base that fills the window scores patterns 0 .. count-1,
// one pattern per cycle out of the store's read port while the result queue
// has room, plus one closing flush slot, then the next request is taken.
// result channel (out_valid / out_stall): one request per matching pattern,
// ascending index, last set on the final one of a base. a match is held
// until the next match or the closing slot is scored.
// results wait in an eight-entry queue; issue of patterns counts credits
// against it, so a stalled receiver slows scoring and nothing is dropped.
// configuration (cfg_valid / cfg_ready): always ready; index 0 limit,
// 1 length, 2 count; write only while the unit is idle.
// reset: window, counters and registers return to defaults (limit 3,
// length 20, count 1); pattern store contents are undefined until loaded.
module degenerate_pattern_mismatch_search_unit (
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic [3:0]        pattern_select,
	input  logic              word_select,
	input  logic [63:0]       pattern_word,
	input  logic [3:0]        base_code,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        pattern_index,
	output logic [31:0]       location,
	output logic signed [7:0] mismatch_count,
	output logic              last,
	// configuration channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [5:0]        cfg_value
);

	localparam int AW = (dpms_pkg::PATTERN_SLOTS > 1) ? $clog2(dpms_pkg::PATTERN_SLOTS) : 1;
	localparam int CW = $clog2(dpms_pkg::PATTERN_SLOTS + 1);
	localparam int LW = $clog2(dpms_pkg::MAX_PATTERN_LEN + 1);

	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_BASE    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	localparam logic [1:0] REG_LIMIT  = 2'd0;
	localparam logic [1:0] REG_LENGTH = 2'd1;
	localparam logic [1:0] REG_COUNT  = 2'd2;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	// configuration registers
	logic [5:0]           limit_q;
	logic [5:0]           len_q;
	logic [4:0]           cnt_q;
	logic [LW-1:0]        len_eff;
	logic [CW-1:0]        cnt_eff;

	// sequencer
	logic                 state_q;
	logic [CW-1:0]        p_q;
	logic                 in_accept;
	logic                 load_wr;
	logic                 base_push;
	logic                 restart;
	logic                 issue;
	dpms_pkg::slot_t      slot_in;

	// datapath links
	dpms_pkg::pat_words_t pat_rd;
	dpms_pkg::pat_words_t align_q;
	logic [31:0]          start_q;
	logic                 will_fill;
	dpms_pkg::score_t     score;
	dpms_pkg::result_t    head;
	logic                 room;
	logic                 pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 6'd3;
			len_q   <= 6'd20;
			cnt_q   <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LIMIT:  limit_q <= cfg_value;
				REG_LENGTH: len_q   <= cfg_value;
				REG_COUNT:  cnt_q   <= cfg_value[4:0];
				default: ;
			endcase
		end
	end

	// length zero counts as one, both fields saturate at what the unit holds
	always_comb begin
		if (len_q == '0) begin
			len_eff = LW'(1);
		end else if (int'(len_q) > dpms_pkg::MAX_PATTERN_LEN) begin
			len_eff = LW'(dpms_pkg::MAX_PATTERN_LEN);
		end else begin
			len_eff = LW'(len_q);
		end
		if (int'(cnt_q) > dpms_pkg::PATTERN_SLOTS) begin
			cnt_eff = CW'(dpms_pkg::PATTERN_SLOTS);
		end else begin
			cnt_eff = CW'(cnt_q);
		end
	end

	// request decode; only taken while the sequencer is idle
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		load_wr   = 1'b0;
		base_push = 1'b0;
		restart   = 1'b0;
		if (in_accept) begin
			unique case (action)
				ACT_LOAD:    load_wr   = (int'(pattern_select) < dpms_pkg::PATTERN_SLOTS);
				ACT_BASE:    base_push = 1'b1;
				ACT_RESTART: restart   = 1'b1;
				default: ;
			endcase
		end
	end

	// one slot per pattern, then a flush slot that releases the held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			p_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (base_push && will_fill && (cnt_eff != '0)) begin
						state_q <= ST_SCAN;
						p_q     <= '0;
					end
				end
				ST_SCAN: begin
					if (room) begin
						if (p_q == cnt_eff) begin
							state_q <= ST_IDLE;
						end else begin
							p_q <= p_q + CW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign issue = (state_q == ST_SCAN) && room;

	always_comb begin
		slot_in.valid    = issue;
		slot_in.flush    = (p_q == cnt_eff);
		slot_in.index    = 4'(p_q);
		slot_in.location = start_q;
	end

	dpms_pattern_mem #(
		.DEPTH (dpms_pkg::PATTERN_SLOTS)
	) u_mem (
		.clk     (clk),
		.wr_en   (load_wr),
		.wr_word (word_select),
		.wr_addr (AW'(pattern_select)),
		.wr_data (pattern_word),
		.rd_addr (p_q[AW-1:0]),
		.rd_data (pat_rd)
	);

	dpms_window #(
		.MAX_LEN (dpms_pkg::MAX_PATTERN_LEN)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (base_push),
		.restart   (restart),
		.base_code (base_code),
		.len_eff   (len_eff),
		.align_q   (align_q),
		.start_q   (start_q),
		.will_fill (will_fill)
	);

	dpms_scorer #(
		.LEN_W (LW)
	) u_scorer (
		.clk     (clk),
		.arst_n  (arst_n),
		.slot_in (slot_in),
		.pat     (pat_rd),
		.win     (align_q),
		.len_eff (len_eff),
		.limit   (limit_q),
		.score   (score)
	);

	assign pop = out_valid && !out_stall;

	dpms_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.score    (score),
		.issue    (issue),
		.pop      (pop),
		.head     (head),
		.has_data (out_valid),
		.room     (room)
	);

	assign pattern_index  = head.pattern_index;
	assign location       = head.location;
	assign mismatch_count = head.mismatch_count;
	assign last           = head.last;

endmodule

FILE: src/dpms_pattern_mem.sv
// pattern store: two word memories with a registered read port
module dpms_pattern_mem #(
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic                 wr_word,
	input  logic [AW-1:0]        wr_addr,
	input  logic [63:0]          wr_data,
	input  logic [AW-1:0]        rd_addr,
	output dpms_pkg::pat_words_t rd_data
);

	logic [dpms_pkg::WORD_BITS-1:0] word0_mem [DEPTH];
	logic [dpms_pkg::WORD_BITS-1:0] word1_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en && !wr_word) begin
			word0_mem[wr_addr] <= wr_data;
		end
		if (wr_en && wr_word) begin
			word1_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data[0] <= word0_mem[rd_addr];
		rd_data[1] <= word1_mem[rd_addr];
	end

endmodule

FILE: src/dpms_window.sv
// sliding base window, fill and position counters, aligned window register
module dpms_window #(
	parameter int MAX_LEN = 32,
	localparam int LEN_W = $clog2(MAX_LEN + 1),
	localparam int WIN_AW = $clog2(MAX_LEN)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 restart,
	input  logic [3:0]           base_code,
	input  logic [LEN_W-1:0]     len_eff,
	output dpms_pkg::pat_words_t align_q,
	output logic [31:0]          start_q,
	output logic                 will_fill
);

	logic [3:0]           win_q [MAX_LEN];
	logic [LEN_W-1:0]     fill_q;
	logic [LEN_W-1:0]     fill_next;
	logic [31:0]          pos_q;
	dpms_pkg::pat_words_t aligned;

	assign fill_next = (int'(fill_q) < MAX_LEN) ? fill_q + LEN_W'(1) : fill_q;
	assign will_fill = (fill_next >= len_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEN; i++) begin
				win_q[i] <= '0;
			end
			fill_q <= '0;
			pos_q  <= '0;
		end else if (restart) begin
			for (int i = 0; i < MAX_LEN; i++) begin
				win_q[i] <= '0;
			end
			fill_q <= '0;
			pos_q  <= '0;
		end else if (push) begin
			for (int i = MAX_LEN - 1; i > 0; i--) begin
				win_q[i] <= win_q[i-1];
			end
			win_q[0] <= base_code;
			fill_q   <= fill_next;
			pos_q    <= pos_q + 32'd1;
		end
	end

	// window start of the base being pushed
	always_ff @(posedge clk) begin
		if (push) begin
			start_q <= pos_q - (32'(len_eff) - 32'd1);
		end
	end

	// oldest base of the window lines up with pattern position zero
	always_comb begin
		aligned = '0;
		for (int i = 0; i < dpms_pkg::PAT_POS; i++) begin
			if (i < int'(len_eff)) begin
				aligned[i / dpms_pkg::BASES_PER_WORD]
					[(dpms_pkg::BASES_PER_WORD - 1 - (i % dpms_pkg::BASES_PER_WORD))
					* dpms_pkg::CODE_BITS +: dpms_pkg::CODE_BITS]
					= win_q[WIN_AW'(int'(len_eff) - 1 - i)];
			end
		end
	end

	always_ff @(posedge clk) begin
		align_q <= aligned;
	end

endmodule

FILE: src/dpms_scorer.sv
// scoring pipeline: and, popcount, mismatch and limit compare
module dpms_scorer #(
	parameter int LEN_W = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dpms_pkg::slot_t      slot_in,
	input  dpms_pkg::pat_words_t pat,
	input  dpms_pkg::pat_words_t win,
	input  logic [LEN_W-1:0]     len_eff,
	input  logic [5:0]           limit,
	output dpms_pkg::score_t     score
);

	function automatic logic [6:0] pop64(input logic [63:0] v);
		logic [2:0] n [16];
		logic [3:0] a [8];
		logic [4:0] b [4];
		logic [5:0] c [2];
		for (int i = 0; i < 16; i++) begin
			n[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
		end
		for (int i = 0; i < 8; i++) begin
			a[i] = 4'(n[2*i]) + 4'(n[2*i+1]);
		end
		for (int i = 0; i < 4; i++) begin
			b[i] = 5'(a[2*i]) + 5'(a[2*i+1]);
		end
		for (int i = 0; i < 2; i++) begin
			c[i] = 6'(b[2*i]) + 6'(b[2*i+1]);
		end
		return 7'(c[0]) + 7'(c[1]);
	endfunction

	dpms_pkg::slot_t   slot_s1;
	dpms_pkg::slot_t   slot_s2;
	logic [6:0]        pc0_s2;
	logic [6:0]        pc1_s2;
	dpms_pkg::score_t  score_s3;
	logic [7:0]        matched;
	logic signed [8:0] diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s1 <= '0;
			slot_s2 <= '0;
		end else begin
			slot_s1 <= slot_in;
			slot_s2 <= slot_s1;
		end
	end

	always_ff @(posedge clk) begin
		pc0_s2 <= pop64(pat[0] & win[0]);
		pc1_s2 <= pop64(pat[1] & win[1]);
	end

	assign matched = 8'(pc0_s2) + 8'(pc1_s2);
	assign diff    = $signed(9'(len_eff)) - $signed({1'b0, matched});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_s3 <= '0;
		end else begin
			score_s3.valid                  <= slot_s2.valid;
			score_s3.flush                  <= slot_s2.flush;
			score_s3.match                  <= (diff <= $signed({3'b000, limit}));
			score_s3.res.pattern_index      <= slot_s2.index;
			score_s3.res.location           <= slot_s2.location;
			score_s3.res.mismatch_count     <= diff[7:0];
			score_s3.res.last               <= 1'b0;
		end
	end

	assign score = score_s3;

endmodule

FILE: src/dpms_out_queue.sv
// held result, result fifo and issue credit count
module dpms_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  dpms_pkg::score_t  score,
	input  logic              issue,
	input  logic              pop,
	output dpms_pkg::result_t head,
	output logic              has_data,
	output logic              room
);

	localparam int DEPTH = 8;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	dpms_pkg::result_t fifo_q [DEPTH];
	logic [PW-1:0]     wptr_q;
	logic [PW-1:0]     rptr_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     resv_q;
	dpms_pkg::result_t pend_q;
	logic              pend_v_q;
	logic              push;
	logic              release_slot;
	logic              take_pend;
	dpms_pkg::result_t push_data;

	// the held match goes out when a later match or the flush slot shows up
	always_comb begin
		push         = score.valid && pend_v_q && (score.flush || score.match);
		take_pend    = score.valid && !score.flush && score.match;
		release_slot = score.valid && !push;
		push_data      = pend_q;
		push_data.last = score.flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			rptr_q   <= '0;
			count_q  <= '0;
			resv_q   <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
			resv_q  <= resv_q + CW'(issue) - CW'(release_slot) - CW'(pop);
			if (take_pend) begin
				pend_v_q <= 1'b1;
			end else if (score.valid && score.flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= push_data;
		end
		if (take_pend) begin
			pend_q <= score.res;
		end
	end

	assign head     = fifo_q[rptr_q];
	assign has_data = (count_q != '0);
	assign room     = (resv_q < CW'(DEPTH));

endmodule
